### design/gnm_pkg.sv
// ----------------------------------------------------------------------------
// gnm_pkg
// Shared types, codes and helpers for the 3x3 grid neighbour marking core.
// ----------------------------------------------------------------------------
package gnm_pkg;

  localparam int CfgW       = 6;
  localparam int ApbDataW   = 32;
  localparam int ApbAddrW   = 3;

  typedef logic [1:0] cell_code_t;

  localparam cell_code_t CELL_CLEAR = 2'd0;
  localparam cell_code_t CELL_SET   = 2'd1;
  localparam cell_code_t CELL_RING  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_GRID_SIZE = 1'b0;

  localparam logic [CfgW-1:0] GRID_SIZE_RESET = 6'd32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_EMIT_A,
    S_EMIT_B,
    S_FL_RD,
    S_FL_DAT,
    S_FL_EMIT,
    S_FL_TAIL
  } state_t;

  function automatic cell_code_t mark(input logic centre, input logic any_set);
    cell_code_t code;
    if (centre) begin
      code = CELL_SET;
    end else if (any_set) begin
      code = CELL_RING;
    end else begin
      code = CELL_CLEAR;
    end
    return code;
  endfunction

endpackage

### design/gnm_stream_if.sv
// ----------------------------------------------------------------------------
// gnm_stream_if
// Valid/ready channels: cell_in_if carries input cells, cell_out_if results.
// ----------------------------------------------------------------------------
interface cell_in_if;
  logic valid;
  logic ready;
  logic cell_in;

  modport source (output valid, output cell_in, input ready);
  modport sink   (input valid, input cell_in, output ready);
endinterface

interface cell_out_if;
  logic                valid;
  logic                ready;
  gnm_pkg::cell_code_t cell_out;
  logic                frame_last;

  modport source (output valid, output cell_out, output frame_last, input ready);
  modport sink   (input valid, input cell_out, input frame_last, output ready);
endinterface

### design/grid_neighbor_marking_3x3_core.sv
// ----------------------------------------------------------------------------
// grid_neighbor_marking_3x3_core
// 3x3 neighbour marking of a square binary grid streamed in raster order.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  in_ch    | in  | valid/ready        | cell_in (1 bit)
//  out_ch   | out | valid/ready        | cell_out (2 bits), frame_last
//  apb      | in  | psel/penable/pready| paddr, pwdata, prdata (grid_size)
//
//  an item is handled as a line store read, then a modify and write back,
//  then one emit state per result it causes; the last cell of a grid adds
//  a flush sweep over the line store, reading each column in turn and
//  emitting the previous column's result, then a final one with frame_last
//  rst clears counters, window and output valid; the line store is not
//  cleared, stale entries read in row 0 before being written reach no result
//  a stalled output holds the core in its emit state; input waits meanwhile
// ----------------------------------------------------------------------------
module grid_neighbor_marking_3x3_core #(
  parameter int MAX_SIDE = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  cell_in_if.sink                         in_ch,
  cell_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gnm_pkg::ApbAddrW-1:0]    paddr,
  input  logic [gnm_pkg::ApbDataW-1:0]    pwdata,
  output logic [gnm_pkg::ApbDataW-1:0]    prdata,
  output logic                            pready
);

  localparam int AW = $clog2(MAX_SIDE);

  // configuration
  logic [gnm_pkg::CfgW-1:0] grid_size;
  logic                     cfg_wr;
  logic [AW-1:0]            side_m1;

  // line store: bit 1 row above, bit 0 centre row
  logic [1:0]    mem [MAX_SIDE];
  logic [1:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [1:0]    mem_wdata;

  gnm_pkg::state_t state, state_next;

  logic [AW-1:0] row_count, row_count_next;
  logic [AW-1:0] col_count, col_count_next;
  logic [AW-1:0] cur_r, cur_r_next;
  logic [AW-1:0] cur_c, cur_c_next;
  logic          cur_bit, cur_bit_next;
  logic          win_v1, win_v1_next;
  logic          win_v2, win_v2_next;
  logic          win_c1, win_c1_next;
  gnm_pkg::cell_code_t res_a, res_a_next;
  gnm_pkg::cell_code_t res_b, res_b_next;
  logic          has_b, has_b_next;
  logic          is_last, is_last_next;
  logic [AW-1:0] fx, fx_next;
  logic          fl_l, fl_l_next;
  logic          fl_m, fl_m_next;
  logic          fl_c, fl_c_next;

  logic                out_valid;
  gnm_pkg::cell_code_t out_code;
  logic                out_last;
  logic                slot_free;
  logic                load;
  gnm_pkg::cell_code_t load_code;
  logic                load_last;

  logic          in_acc;
  logic          c_old, vc, wv1, wv2, wc1, v_new;
  logic          need_a, need_b, last_cell, out_range;

  // ---------------------------------------------------------------- apb port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == gnm_pkg::REG_GRID_SIZE);
  assign prdata = (paddr[2] == gnm_pkg::REG_GRID_SIZE)
                ? {{(gnm_pkg::ApbDataW - gnm_pkg::CfgW){1'b0}}, grid_size}
                : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= gnm_pkg::GRID_SIZE_RESET;
    end else if (cfg_wr) begin
      grid_size <= pwdata[gnm_pkg::CfgW-1:0];
    end
  end

  // side saturated to 1..MAX_SIDE, held as side minus one
  always_comb begin
    if (grid_size == '0) begin
      side_m1 = '0;
    end else if (grid_size > gnm_pkg::CfgW'(MAX_SIDE)) begin
      side_m1 = AW'(MAX_SIDE - 1);
    end else begin
      side_m1 = AW'(grid_size - gnm_pkg::CfgW'(1));
    end
  end

  // ---------------------------------------------------------------- line store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cur_c] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // ---------------------------------------------------------------- datapath
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_range = (col_count > side_m1) || (row_count > side_m1);
  assign slot_free = !out_valid || out_ch.ready;

  assign c_old     = rd_data[0];
  assign vc        = rd_data[1] | rd_data[0] | cur_bit;
  assign wv1       = (cur_c != '0) && win_v1;
  assign wv2       = (cur_c != '0) && win_v2;
  assign wc1       = (cur_c != '0) && win_c1;
  assign need_a    = (cur_r != '0) && (cur_c != '0);
  assign need_b    = (cur_r != '0) && (cur_c == side_m1);
  assign last_cell = (cur_c == side_m1) && (cur_r == side_m1);
  assign v_new     = rd_data[1] | rd_data[0];

  assign mem_wdata = {(cur_r != '0) && c_old, cur_bit};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gnm_pkg::S_IDLE;
      row_count <= '0;
      col_count <= '0;
      win_v1    <= 1'b0;
      win_v2    <= 1'b0;
      win_c1    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      win_v1    <= win_v1_next;
      win_v2    <= win_v2_next;
      win_c1    <= win_c1_next;
      if (cfg_wr) begin
        row_count <= '0;
        col_count <= '0;
      end else begin
        row_count <= row_count_next;
        col_count <= col_count_next;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_r_next;
    cur_c   <= cur_c_next;
    cur_bit <= cur_bit_next;
    res_a   <= res_a_next;
    res_b   <= res_b_next;
    has_b   <= has_b_next;
    is_last <= is_last_next;
    fx      <= fx_next;
    fl_l    <= fl_l_next;
    fl_m    <= fl_m_next;
    fl_c    <= fl_c_next;
    if (load) begin
      out_code <= load_code;
      out_last <= load_last;
    end
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_next     = state;
    row_count_next = row_count;
    col_count_next = col_count;
    cur_r_next     = cur_r;
    cur_c_next     = cur_c;
    cur_bit_next   = cur_bit;
    win_v1_next    = win_v1;
    win_v2_next    = win_v2;
    win_c1_next    = win_c1;
    res_a_next     = res_a;
    res_b_next     = res_b;
    has_b_next     = has_b;
    is_last_next   = is_last;
    fx_next        = fx;
    fl_l_next      = fl_l;
    fl_m_next      = fl_m;
    fl_c_next      = fl_c;
    in_ch.ready    = 1'b0;
    mem_we         = 1'b0;
    load           = 1'b0;
    load_code      = gnm_pkg::CELL_CLEAR;
    load_last      = 1'b0;
    rd_addr        = fx;

    unique case (state)
      gnm_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        rd_addr     = out_range ? '0 : col_count;
        if (in_acc) begin
          cur_r_next   = out_range ? '0 : row_count;
          cur_c_next   = out_range ? '0 : col_count;
          cur_bit_next = in_ch.cell_in;
          state_next   = gnm_pkg::S_LOOK;
        end
      end
      gnm_pkg::S_LOOK: begin
        mem_we       = 1'b1;
        res_a_next   = gnm_pkg::mark(wc1, wv2 | wv1 | vc);
        res_b_next   = gnm_pkg::mark(c_old, wv1 | vc);
        has_b_next   = need_b;
        is_last_next = last_cell;
        win_v2_next  = wv1;
        win_v1_next  = vc;
        win_c1_next  = c_old;
        fx_next      = '0;
        fl_m_next    = 1'b0;
        if (cur_c == side_m1) begin
          col_count_next = '0;
          row_count_next = last_cell ? '0 : cur_r + AW'(1);
        end else begin
          col_count_next = cur_c + AW'(1);
          row_count_next = cur_r;
        end
        priority if (need_a) begin
          state_next = gnm_pkg::S_EMIT_A;
        end else if (need_b) begin
          state_next = gnm_pkg::S_EMIT_B;
        end else if (last_cell) begin
          state_next = gnm_pkg::S_FL_RD;
        end else begin
          state_next = gnm_pkg::S_IDLE;
        end
      end
      gnm_pkg::S_EMIT_A: begin
        if (slot_free) begin
          load      = 1'b1;
          load_code = res_a;
          priority if (has_b) begin
            state_next = gnm_pkg::S_EMIT_B;
          end else if (is_last) begin
            state_next = gnm_pkg::S_FL_RD;
          end else begin
            state_next = gnm_pkg::S_IDLE;
          end
        end
      end
      gnm_pkg::S_EMIT_B: begin
        if (slot_free) begin
          load       = 1'b1;
          load_code  = res_b;
          state_next = is_last ? gnm_pkg::S_FL_RD : gnm_pkg::S_IDLE;
        end
      end
      gnm_pkg::S_FL_RD: begin
        state_next = gnm_pkg::S_FL_DAT;
      end
      gnm_pkg::S_FL_DAT: begin
        // slide the column window; result for the previous column now complete
        fl_l_next  = fl_m;
        fl_m_next  = v_new;
        fl_c_next  = rd_data[0];
        res_a_next = gnm_pkg::mark(fl_c, fl_l | fl_m | v_new);
        priority if (fx != '0) begin
          state_next = gnm_pkg::S_FL_EMIT;
        end else if (fx == side_m1) begin
          state_next = gnm_pkg::S_FL_TAIL;
        end else begin
          fx_next    = fx + AW'(1);
          state_next = gnm_pkg::S_FL_RD;
        end
      end
      gnm_pkg::S_FL_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_code = res_a;
          if (fx == side_m1) begin
            state_next = gnm_pkg::S_FL_TAIL;
          end else begin
            fx_next    = fx + AW'(1);
            state_next = gnm_pkg::S_FL_RD;
          end
        end
      end
      gnm_pkg::S_FL_TAIL: begin
        if (slot_free) begin
          load       = 1'b1;
          load_code  = gnm_pkg::mark(fl_c, fl_l | fl_m);
          load_last  = 1'b1;
          state_next = gnm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = gnm_pkg::S_IDLE;
      end
    endcase
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.cell_out   = out_code;
  assign out_ch.frame_last = out_last;

  // ---------------------------------------------------------------- checks
  a_look_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == gnm_pkg::S_LOOK)
    else $error("accepted item not followed by store look-up");

  a_code_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_code != 2'd3)
    else $error("illegal result code");

  a_flush_in_side: assert property (@(posedge clk) disable iff (rst)
    state == gnm_pkg::S_FL_RD |-> fx <= side_m1)
    else $error("flush sweep beyond grid side");

  a_last_at_grid_start: assert property (@(posedge clk) disable iff (rst)
    (load && load_last) |-> (row_count == '0 && col_count == '0))
    else $error("final result while grid not restarted");

  a_no_write_in_flush: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == gnm_pkg::S_LOOK)
    else $error("line store written outside look-up");

endmodule
